// ===== rtl/thin_lens_ray_generator_macros.svh =====
// ----------------------------------------------------------------------------
// thin lens ray generator assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef THIN_LENS_RAY_GENERATOR_MACROS_SVH
`define THIN_LENS_RAY_GENERATOR_MACROS_SVH

// same-cycle implication
`define TLRG_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLRG_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlrg_pkg.sv =====
// ----------------------------------------------------------------------------
// tlrg_pkg
// transaction types, register indexes and reset values of the ray generator
// ----------------------------------------------------------------------------
package tlrg_pkg;

    // register indexes
    localparam logic [2:0] REG_LENS_RADIUS    = 3'd0;
    localparam logic [2:0] REG_FOCAL_RATIO    = 3'd1;
    localparam logic [2:0] REG_FOCAL_DISTANCE = 3'd2;
    localparam logic [2:0] REG_BASIS_U        = 3'd3;
    localparam logic [2:0] REG_BASIS_V        = 3'd4;
    localparam logic [2:0] REG_BASIS_W        = 3'd5;
    localparam logic [2:0] REG_EYE_POS        = 3'd6;

    // reset values
    localparam logic [15:0] LENS_RADIUS_RST    = 16'd256;
    localparam logic [15:0] FOCAL_RATIO_RST    = 16'd256;
    localparam logic [19:0] FOCAL_DISTANCE_RST = 20'd256;
    localparam logic [47:0] BASIS_U_RST        = 48'h0000_0000_4000;
    localparam logic [47:0] BASIS_V_RST        = 48'h0000_4000_0000;
    localparam logic [47:0] BASIS_W_RST        = 48'h4000_0000_0000;
    localparam logic [59:0] EYE_POS_RST        = 60'd0;

    typedef struct packed {
        logic [2:0]  index;
        logic [59:0] value;
    } t_cfg_item;

    typedef struct packed {
        logic signed [19:0] pixel_x;
        logic signed [19:0] pixel_y;
        logic signed [15:0] disk_x;
        logic signed [15:0] disk_y;
    } t_pix_item;

    typedef struct packed {
        logic signed [19:0] origin_x;
        logic signed [19:0] origin_y;
        logic signed [19:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_ray_item;

endpackage

// ===== rtl/tlrg_stream_if.sv =====
// ----------------------------------------------------------------------------
// tlrg_stream_if
// valid/ready channel carrying one transaction of type T
// ----------------------------------------------------------------------------
interface tlrg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/thin_lens_ray_generator.sv =====
// ----------------------------------------------------------------------------
// thin_lens_ray_generator
// one thin-lens camera ray per sample: saturated origin and unit direction
// throughput: one sample per cycle while the output buffer is not full;
// 56-stage pipeline with a global advance
// a 2-entry output buffer takes rays while the sink stalls; input ready
// drops only when both entries are held
// reset (synchronous, active low): pipeline and buffer emptied, registers
// return to lens 1.0, ratio 1.0, focus 1.0, u/v/w = x/y/z, eye at origin
// ----------------------------------------------------------------------------
`include "thin_lens_ray_generator_macros.svh"

module thin_lens_ray_generator (
    input logic            i_clk,
    input logic            i_rst_n,
    tlrg_stream_if.sink    i_cfg,
    tlrg_stream_if.sink    i_pix,
    tlrg_stream_if.source  o_ray
);
    import tlrg_pkg::*;

    // pipeline stage map
    //   0  lens / focal products
    //   1  rounding, lens point, focal minus lens
    //   2  basis products
    //   3  origin and direction sums
    //   4  origin saturation, direction magnitudes
    //   5  coarse normalize (byte shift)
    //   6  fine normalize (bit shift)
    //   7  squares
    //   8  sum of squares
    //   9..39  square root, one root bit per stage
    //   40     quotient numerators
    //   41..55 division, one quotient bit per stage
    localparam int ST_MUL0  = 0;
    localparam int ST_RND   = 1;
    localparam int ST_MUL1  = 2;
    localparam int ST_ADD   = 3;
    localparam int ST_SAT   = 4;
    localparam int ST_CRS   = 5;
    localparam int ST_FINE  = 6;
    localparam int ST_SQR   = 7;
    localparam int ST_SUM   = 8;
    localparam int ST_SQ0   = 9;
    localparam int SQ_STEPS = 31;
    localparam int ST_LEN   = ST_SQ0 + SQ_STEPS - 1;
    localparam int ST_NUM   = ST_SQ0 + SQ_STEPS;
    localparam int ST_DV0   = ST_NUM + 1;
    localparam int DV_STEPS = 15;
    localparam int NS       = ST_DV0 + DV_STEPS;

    // ------------------------------------------------------------------------
    // configuration registers, always ready, unknown index dropped
    // ------------------------------------------------------------------------
    logic [15:0] r_lens_radius;
    logic [15:0] r_focal_ratio;
    logic [19:0] r_focal_distance;
    logic [47:0] r_basis_u;
    logic [47:0] r_basis_v;
    logic [47:0] r_basis_w;
    logic [59:0] r_eye_pos;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lens_radius    <= LENS_RADIUS_RST;
            r_focal_ratio    <= FOCAL_RATIO_RST;
            r_focal_distance <= FOCAL_DISTANCE_RST;
            r_basis_u        <= BASIS_U_RST;
            r_basis_v        <= BASIS_V_RST;
            r_basis_w        <= BASIS_W_RST;
            r_eye_pos        <= EYE_POS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_LENS_RADIUS:    r_lens_radius    <= i_cfg.data.value[15:0];
                REG_FOCAL_RATIO:    r_focal_ratio    <= i_cfg.data.value[15:0];
                REG_FOCAL_DISTANCE: r_focal_distance <= i_cfg.data.value[19:0];
                REG_BASIS_U:        r_basis_u        <= i_cfg.data.value[47:0];
                REG_BASIS_V:        r_basis_v        <= i_cfg.data.value[47:0];
                REG_BASIS_W:        r_basis_w        <= i_cfg.data.value[47:0];
                REG_EYE_POS:        r_eye_pos        <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // unpacked basis (Q2.14) and eye (Q12.8) components
    logic signed [15:0] w_u [3];
    logic signed [15:0] w_v [3];
    logic signed [15:0] w_w [3];
    logic signed [19:0] w_eye [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_u[k]   = $signed(r_basis_u[16*k +: 16]);
            w_v[k]   = $signed(r_basis_v[16*k +: 16]);
            w_w[k]   = $signed(r_basis_w[16*k +: 16]);
            w_eye[k] = $signed(r_eye_pos[20*k +: 20]);
        end
    end

    // ------------------------------------------------------------------------
    // flow control: whole pipeline advances unless the output buffer is full
    // ------------------------------------------------------------------------
    logic [1:0]    r_cnt;
    logic          w_en;
    logic [NS-1:0] r_vld;
    logic          w_push;
    logic          w_pop;

    assign w_en        = (r_cnt != 2'd2);
    assign i_pix.ready = w_en;
    assign w_push      = w_en && r_vld[NS-1];
    assign w_pop       = o_ray.valid && o_ray.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_pix.valid};
        end
    end

    // ------------------------------------------------------------------------
    // stage 0: disk * lens radius, pixel * focal ratio
    // ------------------------------------------------------------------------
    logic signed [32:0] r_pdx, r_pdy;
    logic signed [36:0] r_ppx, r_ppy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pdx <= i_pix.data.disk_x  * $signed({1'b0, r_lens_radius});
            r_pdy <= i_pix.data.disk_y  * $signed({1'b0, r_lens_radius});
            r_ppx <= i_pix.data.pixel_x * $signed({1'b0, r_focal_ratio});
            r_ppy <= i_pix.data.pixel_y * $signed({1'b0, r_focal_ratio});
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: round half up, lens point, focal minus lens
    // ------------------------------------------------------------------------
    logic signed [32:0] w_pdx_r, w_pdy_r;
    logic signed [36:0] w_ppx_r, w_ppy_r;
    logic signed [19:0] w_lx, w_ly;
    logic signed [29:0] w_fx, w_fy;
    logic signed [19:0] r_lx, r_ly;
    logic signed [29:0] r_a, r_b;

    assign w_pdx_r = r_pdx + 33'sd8192;
    assign w_pdy_r = r_pdy + 33'sd8192;
    assign w_ppx_r = r_ppx + 37'sd128;
    assign w_ppy_r = r_ppy + 37'sd128;
    assign w_lx    = $signed({w_pdx_r[32], w_pdx_r[32:14]});
    assign w_ly    = $signed({w_pdy_r[32], w_pdy_r[32:14]});
    assign w_fx    = $signed({w_ppx_r[36], w_ppx_r[36:8]});
    assign w_fy    = $signed({w_ppy_r[36], w_ppy_r[36:8]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lx <= w_lx;
            r_ly <= w_ly;
            r_a  <= w_fx - 30'(w_lx);
            r_b  <= w_fy - 30'(w_ly);
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: products with the camera basis
    // ------------------------------------------------------------------------
    logic signed [35:0] r_lu [3];
    logic signed [35:0] r_lv [3];
    logic signed [45:0] r_au [3];
    logic signed [45:0] r_bv [3];
    logic signed [36:0] r_fw [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_lu[k] <= r_lx * w_u[k];
                r_lv[k] <= r_ly * w_v[k];
                r_au[k] <= r_a * w_u[k];
                r_bv[k] <= r_b * w_v[k];
                r_fw[k] <= $signed({1'b0, r_focal_distance}) * w_w[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 3: origin sum in Q.22 with rounding bias, exact direction in Q.22
    // ------------------------------------------------------------------------
    logic signed [23:0] r_os [3];
    logic signed [47:0] r_c  [3];
    logic signed [37:0] w_osum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_osum[k] = 38'($signed({w_eye[k], 14'd0})) + 38'(r_lu[k]) + 38'(r_lv[k])
                      + 38'sd8192;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_os[k] <= w_osum[k][37:14];
                r_c[k]  <= 48'(r_au[k]) + 48'(r_bv[k]) - 48'(r_fw[k]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 4: origin saturation, direction sign and magnitude
    // ------------------------------------------------------------------------
    logic [2:0][19:0] r_org [ST_SAT:NS-1];
    logic [2:0]       r_sgn [ST_SAT:NS-1];
    logic [47:0]      r_mag [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                if (r_os[k] > 24'sd524287) begin
                    r_org[ST_SAT][k] <= 20'h7FFFF;
                end else if (r_os[k] < -24'sd524288) begin
                    r_org[ST_SAT][k] <= 20'h80000;
                end else begin
                    r_org[ST_SAT][k] <= r_os[k][19:0];
                end
                r_sgn[ST_SAT][k] <= r_c[k][47];
                r_mag[k]         <= r_c[k][47] ? 48'(-r_c[k]) : 48'(r_c[k]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 5: coarse normalize; the largest magnitude and the or of all
    // three share their leading one, so the or drives the shift
    // ------------------------------------------------------------------------
    logic [47:0] w_mx;
    logic [2:0]  w_csh;
    logic [47:0] r_cm [3];
    logic        r_zero [ST_CRS:NS-1];

    assign w_mx = r_mag[0] | r_mag[1] | r_mag[2];

    always_comb begin
        w_csh = 3'd0;
        for (int ch = 0; ch < 6; ch++) begin
            if (|w_mx[8*ch +: 8]) begin
                w_csh = 3'(5 - ch);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_cm[k] <= r_mag[k] << {w_csh, 3'b000};
            end
            r_zero[ST_CRS] <= ~|w_mx;
        end
    end

    // ------------------------------------------------------------------------
    // stage 6: fine normalize; leading one to bit 47, keep bits 47:18 so the
    // largest lands in [2^29, 2^30) with low bits truncated
    // ------------------------------------------------------------------------
    logic [47:0]      w_cmx;
    logic [2:0]       w_fsh;
    logic [47:0]      w_fsv [3];
    logic [2:0][29:0] r_nm [ST_FINE:ST_NUM-1];

    assign w_cmx = r_cm[0] | r_cm[1] | r_cm[2];

    always_comb begin
        w_fsh = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (w_cmx[40 + b]) begin
                w_fsh = 3'(7 - b);
            end
        end
        for (int k = 0; k < 3; k++) begin
            w_fsv[k] = r_cm[k] << w_fsh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_nm[ST_FINE][k] <= w_fsv[k][47:18];
            end
        end
    end

    // ------------------------------------------------------------------------
    // stages 7, 8: squares and their sum
    // ------------------------------------------------------------------------
    logic [59:0] r_sqr [3];
    logic [61:0] r_sum [ST_SUM:ST_LEN-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sqr[k] <= r_nm[ST_FINE][k] * r_nm[ST_FINE][k];
            end
            r_sum[ST_SUM] <= 62'(r_sqr[0]) + 62'(r_sqr[1]) + 62'(r_sqr[2]);
        end
    end

    // ------------------------------------------------------------------------
    // stages 9..39: digit-by-digit square root, floor of the root
    // ------------------------------------------------------------------------
    logic [30:0] r_rt [ST_SQ0:ST_LEN];
    logic [33:0] r_rm [ST_SQ0:ST_LEN-1];

    for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_sqrt
        localparam int ST = ST_SQ0 + gi;
        localparam int PB = 61 - 2 * gi;
        logic [30:0] w_rt_in;
        logic [33:0] w_rm_in;
        logic [33:0] w_rmx;
        logic [33:0] w_trial;
        logic        w_ge;

        if (gi == 0) begin : g_first
            assign w_rt_in = '0;
            assign w_rm_in = '0;
        end else begin : g_next
            assign w_rt_in = r_rt[ST-1];
            assign w_rm_in = r_rm[ST-1];
        end

        assign w_rmx   = {w_rm_in[31:0], r_sum[ST-1][PB -: 2]};
        assign w_trial = {1'b0, w_rt_in, 2'b01};
        assign w_ge    = (w_rmx >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rt[ST] <= {w_rt_in[29:0], w_ge};
            end
        end

        if (gi < SQ_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rm[ST]  <= w_ge ? (w_rmx - w_trial) : w_rmx;
                    r_sum[ST] <= r_sum[ST-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 40: numerators mag * 2^14 + len / 2
    // ------------------------------------------------------------------------
    logic [2:0][44:0] r_rem [ST_NUM:NS-2];
    logic [30:0]      r_len [ST_NUM:NS-2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[ST_NUM][k] <= {1'b0, r_nm[ST_NUM-1][k], 14'd0}
                                  + {15'd0, r_rt[ST_LEN][30:1]};
            end
            r_len[ST_NUM] <= r_rt[ST_LEN];
        end
    end

    // ------------------------------------------------------------------------
    // stages 41..55: restoring division, quotient msb first, three lanes
    // ------------------------------------------------------------------------
    logic [2:0][14:0] r_qt [ST_DV0:NS-1];

    for (genvar gj = 0; gj < DV_STEPS; gj++) begin : g_div
        localparam int ST = ST_DV0 + gj;
        localparam int QB = DV_STEPS - 1 - gj;
        logic [45:0]      w_dvs;
        logic [2:0]       w_ge;
        logic [2:0][14:0] w_q_in;

        assign w_dvs = 46'(r_len[ST-1]) << QB;

        if (gj == 0) begin : g_first
            assign w_q_in = '0;
        end else begin : g_next
            assign w_q_in = r_qt[ST-1];
        end

        for (genvar gk = 0; gk < 3; gk++) begin : g_lane
            assign w_ge[gk] = ({1'b0, r_rem[ST-1][gk]} >= w_dvs);

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_qt[ST][gk] <= {w_q_in[gk][13:0], w_ge[gk]};
                end
            end

            if (gj < DV_STEPS - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_rem[ST][gk] <= w_ge[gk] ? (r_rem[ST-1][gk] - w_dvs[44:0])
                                                  : r_rem[ST-1][gk];
                    end
                end
            end
        end

        if (gj < DV_STEPS - 1) begin : g_len
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_len[ST] <= r_len[ST-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // side-band travel: origin, signs, zero flag, normalized magnitudes
    // ------------------------------------------------------------------------
    for (genvar gs = ST_SAT + 1; gs < NS; gs++) begin : g_org
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_org[gs] <= r_org[gs-1];
                r_sgn[gs] <= r_sgn[gs-1];
            end
        end
    end

    for (genvar gz = ST_CRS + 1; gz < NS; gz++) begin : g_zero
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_zero[gz] <= r_zero[gz-1];
            end
        end
    end

    for (genvar gn = ST_FINE + 1; gn < ST_NUM; gn++) begin : g_nm
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_nm[gn] <= r_nm[gn-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // ray assembly: apply signs, force zero direction
    // ------------------------------------------------------------------------
    t_ray_item          w_item;
    logic signed [15:0] w_dir [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_zero[NS-1]) begin
                w_dir[k] = 16'sd0;
            end else if (r_sgn[NS-1][k]) begin
                w_dir[k] = -$signed({1'b0, r_qt[NS-1][k]});
            end else begin
                w_dir[k] = $signed({1'b0, r_qt[NS-1][k]});
            end
        end
        w_item.origin_x = $signed(r_org[NS-1][0]);
        w_item.origin_y = $signed(r_org[NS-1][1]);
        w_item.origin_z = $signed(r_org[NS-1][2]);
        w_item.dir_x    = w_dir[0];
        w_item.dir_y    = w_dir[1];
        w_item.dir_z    = w_dir[2];
    end

    // ------------------------------------------------------------------------
    // 2-entry output buffer: head register plus skid entry
    // ------------------------------------------------------------------------
    t_ray_item r_q0, r_q1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
            end else if (w_push) begin
                r_q0 <= w_item;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_item;
            end else begin
                r_q1 <= w_item;
            end
        end
    end

    assign o_ray.valid = (r_cnt != 2'd0);
    assign o_ray.data  = r_q0;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `TLRG_ASSERT_NXT(a_accept_enters, i_pix.valid && i_pix.ready, r_vld[0], "sample transaction lost at pipeline entry")
    `TLRG_ASSERT_IMP(a_dir_nonzero, r_vld[NS-1] && !r_zero[NS-1], r_qt[NS-1] != '0, "nonzero direction normalized to zero")
    `TLRG_ASSERT_IMP(a_dir_unit, o_ray.valid, (o_ray.data.dir_x <= 16'sd16384) && (o_ray.data.dir_x >= -16'sd16384) && (o_ray.data.dir_y <= 16'sd16384) && (o_ray.data.dir_y >= -16'sd16384) && (o_ray.data.dir_z <= 16'sd16384) && (o_ray.data.dir_z >= -16'sd16384), "direction component beyond unit length")

endmodule
